// ===== sv/binary_max_heap_assert.svh =====
// assertion macros for the heap queue
`ifndef BINARY_MAX_HEAP_ASSERT_SVH
`define BINARY_MAX_HEAP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BMH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heap check failed");

// next-cycle implication, checked out of reset
`define BMH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heap check failed");

`endif

// ===== sv/bmh_pkg.sv =====
package bmh_pkg;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     occ;
  } cell_ctrl_t;

  localparam int unsigned LIMIT_W     = 9;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

endpackage

// ===== sv/binary_max_heap.sv =====
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_cmd, in_value
// out      output     out_valid / out_ready  out_status, out_top_value,
//                                            out_top_valid, out_entry_count
// cfg      input      cfg_wr_en (no wait)    cfg_wr_data (heap_limit)
//
// one item per cycle: the row of cells updates in the cycle of the transfer,
// with every cell comparing against the new value and shifting by one slot
// the result sits in an output register; a new item is taken while it drains
// reset (synchronous, rst_n low) empties the queue and sets the limit to 256
// a stalled output holds off input only while the output register is full
module binary_max_heap #(
  parameter int unsigned MAX_ENTRIES = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [bmh_pkg::LIMIT_W-1:0]         cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_cmd,
  input  logic signed [VALUE_WIDTH-1:0]       in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic signed [VALUE_WIDTH-1:0]       out_top_value,
  output logic                                out_top_valid,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]    out_entry_count
);
  import bmh_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned LW    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  logic [LIMIT_W-1:0]           limit_r;
  logic [CNT_W-1:0]             count_r;
  logic [CNT_W-1:0]             count_nxt;
  logic                         out_valid_r;
  logic [1:0]                   out_status_r;
  logic [1:0]                   out_status_nxt;
  logic signed [VALUE_WIDTH-1:0] out_top_r;
  logic signed [VALUE_WIDTH-1:0] out_top_nxt;
  logic                         out_top_valid_r;
  logic [CNT_W-1:0]             out_count_r;

  logic                         in_fire;
  logic                         full;
  logic [LW-1:0]                eff_limit;
  cell_op_t                     op;

  logic signed [VALUE_WIDTH-1:0] cell_val [MAX_ENTRIES];
  logic                          cell_keep [MAX_ENTRIES];
  cell_ctrl_t                    cell_ctrl [MAX_ENTRIES];

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // limit above the capacity saturates
  assign eff_limit = (LW'(limit_r) > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : LW'(limit_r);
  assign full      = LW'(count_r) >= eff_limit;

  always_comb begin
    op             = CELL_HOLD;
    count_nxt      = count_r;
    out_status_nxt = ST_OK;
    out_top_nxt    = (count_r != '0) ? cell_val[0] : '0;
    if (in_cmd == CMD_INSERT) begin
      if (full) begin
        out_status_nxt = ST_OVERFLOW;
      end else begin
        op        = CELL_INSERT;
        count_nxt = count_r + CNT_W'(1);
        if ((count_r == '0) || (in_value > cell_val[0])) begin
          out_top_nxt = in_value;
        end
      end
    end else begin
      if (count_r == '0) begin
        out_status_nxt = ST_UNDERFLOW;
      end else begin
        op          = CELL_REMOVE;
        count_nxt   = count_r - CNT_W'(1);
        out_top_nxt = (count_r > CNT_W'(1)) ? cell_val[1] : '0;
      end
    end
    if (!in_fire) begin
      op        = CELL_HOLD;
      count_nxt = count_r;
    end
  end

  // sorted row, largest in cell 0
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    assign cell_ctrl[i].op  = op;
    assign cell_ctrl[i].occ = count_r > CNT_W'(i);

    if (i == 0) begin : g_first
      bmh_cell #(.VW(VALUE_WIDTH)) u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl[i]),
        .ins_value  (in_value),
        .prev_value (in_value),
        .prev_keep  (1'b1),
        .next_value (cell_val[i+1]),
        .keep       (cell_keep[i]),
        .value      (cell_val[i])
      );
    end else if (i == MAX_ENTRIES - 1) begin : g_last
      bmh_cell #(.VW(VALUE_WIDTH)) u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl[i]),
        .ins_value  (in_value),
        .prev_value (cell_val[i-1]),
        .prev_keep  (cell_keep[i-1]),
        .next_value (cell_val[i]),
        .keep       (cell_keep[i]),
        .value      (cell_val[i])
      );
    end else begin : g_mid
      bmh_cell #(.VW(VALUE_WIDTH)) u_cell (
        .clk        (clk),
        .ctrl       (cell_ctrl[i]),
        .ins_value  (in_value),
        .prev_value (cell_val[i-1]),
        .prev_keep  (cell_keep[i-1]),
        .next_value (cell_val[i+1]),
        .keep       (cell_keep[i]),
        .value      (cell_val[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r    <= out_status_nxt;
      out_top_r       <= out_top_nxt;
      out_top_valid_r <= count_nxt != '0;
      out_count_r     <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_top_value   = out_top_r;
  assign out_top_valid   = out_top_valid_r;
  assign out_entry_count = out_count_r;

`include "binary_max_heap_assert.svh"

  `BMH_ASSERT_NOW(a_count_cap, 1'b1, count_r <= CNT_W'(MAX_ENTRIES))
  `BMH_ASSERT_NEXT(a_overflow_keeps, in_fire && (in_cmd == CMD_INSERT) && full, (out_status_r == ST_OVERFLOW) && (count_r == $past(count_r)))
  `BMH_ASSERT_NEXT(a_remove_drops, in_fire && (in_cmd == CMD_REMOVE) && (count_r != '0), count_r == $past(count_r) - CNT_W'(1))
  `BMH_ASSERT_NOW(a_top_valid_count, out_valid_r, out_top_valid_r == (out_count_r != '0))

endmodule

// ===== sv/bmh_cell.sv =====
module bmh_cell #(
  parameter int unsigned VW = 32
) (
  input  logic                 clk,
  input  bmh_pkg::cell_ctrl_t  ctrl,
  input  logic signed [VW-1:0] ins_value,
  input  logic signed [VW-1:0] prev_value,
  input  logic                 prev_keep,
  input  logic signed [VW-1:0] next_value,
  output logic                 keep,
  output logic signed [VW-1:0] value
);
  import bmh_pkg::*;

  logic signed [VW-1:0] val_r;
  logic signed [VW-1:0] val_nxt;

  // occupied and not smaller than the new value: stays in place on insert
  assign keep  = ctrl.occ && !(ins_value > val_r);
  assign value = val_r;

  always_comb begin
    unique case (ctrl.op)
      CELL_INSERT: begin
        if (keep) begin
          val_nxt = val_r;
        end else if (prev_keep) begin
          val_nxt = ins_value;
        end else begin
          val_nxt = prev_value;
        end
      end
      CELL_REMOVE: val_nxt = next_value;
      default:     val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
